// ===== hdl/atge_pkg.sv =====
// Shared constants, types and helper functions of the terminal grid engine.
package atge_pkg;

   localparam int ROWS       = 32;
   localparam int COLS       = 64;
   localparam int SCROLLBACK = 256;
   localparam int SEQ_MAX    = 16;
   localparam int SGR_MAX    = 16;

   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLS);
   localparam int CUR_COL_W = $clog2(COLS + 1);
   localparam int SB_W      = $clog2(SCROLLBACK);
   localparam int RP_W      = $clog2(SCROLLBACK + 1);
   localparam int LOG_W     = $clog2(SCROLLBACK + 2 * 64 + 1);
   localparam int SEQ_IW    = $clog2(SEQ_MAX);
   localparam int SEQ_LW    = $clog2(SEQ_MAX + 1);
   localparam int PN_W      = $clog2(SGR_MAX + 3);
   localparam int ADDR_W    = SB_W + COL_W;
   localparam int DEPTH     = SCROLLBACK << COL_W;
   localparam int SUM_W     = ((SB_W > 10) ? SB_W : 10) + 2;

   localparam int CHAR_W = 8;
   localparam int ATTR_W = 10;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int PARAM_W = 16;

   // fixed field widths
   localparam int CMD_W   = 2;
   localparam int VROW_W  = 5;
   localparam int VCOL_W  = 6;
   localparam int DELTA_W = 10;
   localparam int OROW_W  = 5;
   localparam int OCOL_W  = 6;
   localparam int PAN_W   = 8;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 48;

   localparam logic [CMD_W-1:0] CMD_FEED   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

   localparam logic [ATTR_W-1:0] DFLT_ATTR = 10'h088;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3f;
   localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_VT     = 8'h0b;
   localparam logic [CHAR_W-1:0] CH_FF     = 8'h0c;
   localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7e;
   localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_HIGH   = 8'h80;
   localparam logic [CHAR_W-1:0] UTF_MASK  = 8'hc0;

   localparam logic [CHAR_W-1:0] F_CUP = 8'h48;  // H
   localparam logic [CHAR_W-1:0] F_HVP = 8'h66;  // f
   localparam logic [CHAR_W-1:0] F_CUU = 8'h41;  // A
   localparam logic [CHAR_W-1:0] F_CUD = 8'h42;  // B
   localparam logic [CHAR_W-1:0] F_CUF = 8'h43;  // C
   localparam logic [CHAR_W-1:0] F_CUB = 8'h44;  // D
   localparam logic [CHAR_W-1:0] F_CHA = 8'h47;  // G
   localparam logic [CHAR_W-1:0] F_VPA = 8'h64;  // d
   localparam logic [CHAR_W-1:0] F_EL  = 8'h4b;  // K
   localparam logic [CHAR_W-1:0] F_ED  = 8'h4a;  // J
   localparam logic [CHAR_W-1:0] F_SGR = 8'h6d;  // m

   localparam logic [PARAM_W-1:0] SGR_RESET   = 16'd0;
   localparam logic [PARAM_W-1:0] SGR_BOLD    = 16'd1;
   localparam logic [PARAM_W-1:0] SGR_INV     = 16'd7;
   localparam logic [PARAM_W-1:0] SGR_NOBOLD  = 16'd22;
   localparam logic [PARAM_W-1:0] SGR_NOINV   = 16'd27;
   localparam logic [PARAM_W-1:0] SGR_FG_LO   = 16'd30;
   localparam logic [PARAM_W-1:0] SGR_FG_HI   = 16'd37;
   localparam logic [PARAM_W-1:0] SGR_FG_DFLT = 16'd39;
   localparam logic [PARAM_W-1:0] SGR_BG_LO   = 16'd40;
   localparam logic [PARAM_W-1:0] SGR_BG_HI   = 16'd47;
   localparam logic [PARAM_W-1:0] SGR_BG_DFLT = 16'd49;
   localparam logic [PARAM_W-1:0] PARAM_SAT   = 16'hffff;

   typedef struct packed {
      logic              clear;
      logic              step;
      logic              finish;
      logic              dflt_one;
      logic [CHAR_W-1:0] chr;
   } pu_ctl_type;

   typedef struct packed {
      logic               emit;
      logic [PARAM_W-1:0] value;
   } pu_out_type;

   function automatic logic [SB_W-1:0] phys_row(input logic [SB_W-1:0] base,
                                                  input logic [LOG_W-1:0] logical);
      logic [LOG_W:0] sum;
      sum = (LOG_W + 1)'(base) + (LOG_W + 1)'(logical);
      if (sum >= (LOG_W + 1)'(SCROLLBACK)) begin
         sum = sum - (LOG_W + 1)'(SCROLLBACK);
      end
      return sum[SB_W-1:0];
   endfunction

   function automatic logic [ATTR_W-1:0] apply_sgr(input logic [ATTR_W-1:0] attr,
                                                    input logic [PARAM_W-1:0] code);
      logic [PARAM_W-1:0] fg;
      logic [PARAM_W-1:0] bg;
      logic [ATTR_W-1:0]  res;
      fg  = code - SGR_FG_LO;
      bg  = code - SGR_BG_LO;
      res = attr;
      if (code == SGR_RESET) res = DFLT_ATTR;
      else if (code == SGR_BOLD) res[8] = 1'b1;
      else if (code == SGR_INV) res[9] = 1'b1;
      else if (code == SGR_NOBOLD) res[8] = 1'b0;
      else if (code == SGR_NOINV) res[9] = 1'b0;
      else if (code >= SGR_FG_LO && code <= SGR_FG_HI) res[3:0] = fg[3:0];
      else if (code == SGR_FG_DFLT) res[3:0] = 4'd8;
      else if (code >= SGR_BG_LO && code <= SGR_BG_HI) res[7:4] = bg[3:0];
      else if (code == SGR_BG_DFLT) res[7:4] = 4'd8;
      return res;
   endfunction

endpackage

// ===== hdl/atge_ram.sv =====
// Generic single-port RAM with registered read.
module atge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/atge_param.sv =====
// CSI parameter accumulator: decimal digits, saturation and separators.
module atge_param (
   input  logic                 clock,
   input  logic                 reset,
   input  atge_pkg::pu_ctl_type ctl,
   output atge_pkg::pu_out_type res
);
   import atge_pkg::*;

   logic [PARAM_W-1:0] val_ff, val_in;
   logic               have_ff, have_in;
   logic [PARAM_W+3:0] prod;
   logic               is_digit;
   logic [CHAR_W-1:0]  digit;

   assign is_digit = (ctl.chr >= CH_ZERO) && (ctl.chr <= CH_NINE);
   assign digit    = ctl.chr - CH_ZERO;
   assign prod     = {val_ff, 3'b000} + {2'b00, val_ff, 1'b0} + (PARAM_W + 4)'(digit);

   always_comb begin
      val_in    = val_ff;
      have_in   = have_ff;
      res.emit  = 1'b0;
      res.value = have_ff ? val_ff : PARAM_W'(ctl.dflt_one);
      if (ctl.clear) begin
         val_in  = '0;
         have_in = 1'b0;
      end else if (ctl.step) begin
         if (is_digit) begin
            val_in  = (prod > (PARAM_W + 4)'(PARAM_SAT)) ? PARAM_SAT : prod[PARAM_W-1:0];
            have_in = 1'b1;
         end else if (ctl.chr == CH_SEMI) begin
            res.emit = 1'b1;
            val_in   = '0;
            have_in  = 1'b0;
         end
      end else if (ctl.finish) begin
         res.emit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff  <= '0;
         have_ff <= 1'b0;
      end else begin
         val_ff  <= val_in;
         have_ff <= have_in;
      end
   end

endmodule

// ===== hdl/ansi_terminal_grid_engine.sv =====
// Top level of the terminal grid engine: command sequencer and grid memory.
//
// Usage: one request transaction on req_* carries a command: feed one host
// byte, read one cell of the panned view, or pan the view. Every request
// gives exactly one response transaction on rsp_* with the read cell (zero
// for commands other than a read) and the cursor and pan status after it.
// The block works on one request at a time; req_tready is high only while
// the sequencer is idle. A plain byte, pan or status command goes from idle
// straight to ST_DONE; a printed byte passes ST_WRITE, a read ST_RD_CALC,
// ST_RD_ADDR and ST_RD_DATA, and a CSI final byte ST_PARSE once per stored
// sequence byte, then ST_PFIN and ST_EXEC. A line feed at the bottom row
// clears one row of the ring through the single grid port, and an erase
// clears its cells one per cycle (ROWS*COLS cells for a full screen erase).
// Reset: synchronous, active high. After reset the block clears the first
// ROWS rows of the ring before it accepts a request.
// Stall: a finished response waits in the output register; the block takes
// the next request meanwhile and holds before its own response until the
// register is free.
module ansi_terminal_grid_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // cmd[1:0], data_byte[9:2], view_row[14:10], view_col[20:15],
   // scroll_delta[30:21], zero [31]
   input  logic [atge_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // cell_char[7:0], cell_attr[17:8], cursor_row[22:18], cursor_col[28:23],
   // view_offset[36:29], view_max[44:37], zero [47:45]
   output logic [atge_pkg::RSP_W-1:0]  rsp_tdata
);
   import atge_pkg::*;

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_WRITE, ST_RD_CALC, ST_RD_ADDR, ST_RD_DATA,
      ST_PARSE, ST_PFIN, ST_EXEC, ST_DONE
   } state_type;

   typedef enum logic [1:0] {PH_GROUND, PH_ESC, PH_CSI} phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [CUR_COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ATTR_W-1:0]   pen_ff, pen_in;
   logic [SB_W-1:0]     ring_ff, ring_in;
   logic [RP_W-1:0]     rows_ff, rows_in;
   logic [SB_W-1:0]     pan_ff, pan_in;
   logic [CHAR_W-1:0]   seq_ff [SEQ_MAX];
   logic                seq_we;
   logic [SEQ_LW-1:0]   seq_len_ff, seq_len_in;
   logic [CHAR_W-1:0]   glyph_ff, glyph_in;
   logic                glyph_pend_ff, glyph_pend_in;
   logic                boot_ff, boot_in;
   logic [CHAR_W-1:0]   fin_ff, fin_in;
   logic [SEQ_IW-1:0]   pidx_ff, pidx_in;
   logic [PN_W-1:0]     pn_ff, pn_in;
   logic [PARAM_W-1:0]  p0_ff, p0_in, p1_ff, p1_in;
   logic [VROW_W-1:0]   vrow_ff, vrow_in;
   logic [VCOL_W-1:0]   vcol_ff, vcol_in;
   logic [LOG_W-1:0]    rd_log_ff, rd_log_in;
   logic                rd_hit_ff, rd_hit_in;
   logic [CHAR_W-1:0]   cell_ch_ff, cell_ch_in;
   logic [ATTR_W-1:0]   cell_at_ff, cell_at_in;
   logic [SB_W-1:0]     sw_phys_ff, sw_phys_in;
   logic [COL_W-1:0]    sw_col_ff, sw_col_in;
   logic [COL_W-1:0]    sw_cend_ff, sw_cend_in;
   logic [ROW_W-1:0]    sw_rows_ff, sw_rows_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [CELL_W-1:0]   ram_wdata, ram_rdata;
   pu_ctl_type          pu_ctl;
   pu_out_type          pu_res;

   logic [CMD_W-1:0]    q_cmd;
   logic [CHAR_W-1:0]   q_byte;
   logic [VROW_W-1:0]   q_vrow;
   logic [VCOL_W-1:0]   q_vcol;
   logic [DELTA_W-1:0]  q_delta;
   logic                accept;
   logic [RP_W-1:0]     screen_top;
   logic [PN_W-1:0]     pmax;
   logic [COL_W-1:0]    edge_col;
   logic [LOG_W-1:0]    cur_logical;
   logic [PARAM_W-1:0]  step;
   logic [PARAM_W:0]    sum_wide;
   logic signed [SUM_W-1:0] pan_sum;
   logic [CUR_COL_W:0]  tab_next;
   logic [RP_W:0]       rd_top;
   logic [CELL_W-1:0]   blank;

   assign q_cmd   = req_tdata[1:0];
   assign q_byte  = req_tdata[9:2];
   assign q_vrow  = req_tdata[14:10];
   assign q_vcol  = req_tdata[20:15];
   assign q_delta = req_tdata[30:21];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign blank      = {DFLT_ATTR, CH_SPACE};

   assign screen_top  = (rows_ff > RP_W'(ROWS)) ? rows_ff - RP_W'(ROWS) : '0;
   assign cur_logical = LOG_W'(screen_top) + LOG_W'(cur_row_ff);
   assign edge_col    = (cur_col_ff < CUR_COL_W'(COLS)) ? cur_col_ff[COL_W-1:0]
                                                        : COL_W'(COLS - 1);
   assign step        = (p0_ff == '0) ? PARAM_W'(1) : p0_ff;

   // absolute row and column positions, one-based with zero meaning one
   function automatic logic [ROW_W-1:0] abs_row(input logic [PARAM_W-1:0] p);
      logic [PARAM_W-1:0] m;
      m = p - PARAM_W'(1);
      if (p == '0) return '0;
      if (p > PARAM_W'(ROWS)) return ROW_W'(ROWS - 1);
      return m[ROW_W-1:0];
   endfunction

   function automatic logic [CUR_COL_W-1:0] abs_col(input logic [PARAM_W-1:0] p);
      logic [PARAM_W-1:0] m;
      m = p - PARAM_W'(1);
      if (p == '0) return '0;
      if (p > PARAM_W'(COLS + 1)) return CUR_COL_W'(COLS);
      return m[CUR_COL_W-1:0];
   endfunction

   always_comb begin
      case (fin_ff)
         F_CUP, F_HVP: pmax = PN_W'(2);
         F_SGR:        pmax = PN_W'(SGR_MAX);
         default:      pmax = PN_W'(1);
      endcase
   end

   atge_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   atge_param u_param (
      .clock (clock),
      .reset (reset),
      .ctl   (pu_ctl),
      .res   (pu_res)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      pen_in        = pen_ff;
      ring_in       = ring_ff;
      rows_in       = rows_ff;
      pan_in        = pan_ff;
      seq_we        = 1'b0;
      seq_len_in    = seq_len_ff;
      glyph_in      = glyph_ff;
      glyph_pend_in = glyph_pend_ff;
      boot_in       = boot_ff;
      fin_in        = fin_ff;
      pidx_in       = pidx_ff;
      pn_in         = pn_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      vrow_in       = vrow_ff;
      vcol_in       = vcol_ff;
      rd_log_in     = rd_log_ff;
      rd_hit_in     = rd_hit_ff;
      cell_ch_in    = cell_ch_ff;
      cell_at_in    = cell_at_ff;
      sw_phys_in    = sw_phys_ff;
      sw_col_in     = sw_col_ff;
      sw_cend_in    = sw_cend_ff;
      sw_rows_in    = sw_rows_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_addr      = {sw_phys_ff, sw_col_ff};
      ram_wdata     = blank;
      pu_ctl        = '{clear: (state_ff == ST_IDLE), step: 1'b0, finish: 1'b0,
                        dflt_one: !(fin_ff == F_EL || fin_ff == F_ED || fin_ff == F_SGR),
                        chr: seq_ff[pidx_ff]};
      sum_wide      = '0;
      pan_sum       = '0;
      tab_next      = '0;
      rd_top        = '0;

      case (state_ff)
         ST_SWEEP: begin
            // blank one cell per cycle, row by row
            ram_we = 1'b1;
            if (sw_col_ff == sw_cend_ff) begin
               if (sw_rows_ff == '0) begin
                  boot_in = 1'b0;
                  if (glyph_pend_ff) state_in = ST_WRITE;
                  else if (boot_ff) state_in = ST_IDLE;
                  else state_in = ST_DONE;
               end else begin
                  sw_rows_in = sw_rows_ff - 1'b1;
                  sw_phys_in = (sw_phys_ff == SB_W'(SCROLLBACK - 1)) ? '0
                                                                   : sw_phys_ff + 1'b1;
                  sw_col_in  = '0;
                  sw_cend_in = COL_W'(COLS - 1);
               end
            end else begin
               sw_col_in = sw_col_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               cell_ch_in = '0;
               cell_at_in = '0;
               vrow_in    = q_vrow;
               vcol_in    = q_vcol;
               state_in   = ST_DONE;
               case (q_cmd)
                  CMD_FEED: begin
                     pan_in = '0;
                     case (phase_ff)
                        PH_GROUND: begin
                           if (q_byte == CH_ESC) begin
                              phase_in = PH_ESC;
                           end else if (q_byte == CH_CR) begin
                              cur_col_in = '0;
                           end else if (q_byte == CH_BS) begin
                              if (cur_col_ff != '0) cur_col_in = cur_col_ff - 1'b1;
                           end else if (q_byte == CH_TAB) begin
                              tab_next = ((CUR_COL_W + 1)'(cur_col_ff >> 3) + 1'b1) << 3;
                              cur_col_in = (tab_next >= (CUR_COL_W + 1)'(COLS))
                                           ? CUR_COL_W'(COLS - 1) : tab_next[CUR_COL_W-1:0];
                           end else if (q_byte == CH_LF || q_byte == CH_VT ||
                                        q_byte == CH_FF ||
                                        (q_byte >= CH_SPACE && q_byte <= CH_TILDE) ||
                                        (q_byte >= CH_HIGH &&
                                         (q_byte & UTF_MASK) != CH_HIGH)) begin
                              // printing byte or line feed
                              glyph_in      = (q_byte >= CH_HIGH) ? CH_QMARK : q_byte;
                              glyph_pend_in = !(q_byte == CH_LF || q_byte == CH_VT ||
                                                q_byte == CH_FF);
                              if (glyph_pend_in && cur_col_ff < CUR_COL_W'(COLS)) begin
                                 state_in = ST_WRITE;
                              end else begin
                                 // next line, possibly pushing a row into the ring
                                 cur_col_in = '0;
                                 if (cur_row_ff >= ROW_W'(ROWS - 1)) begin
                                    cur_row_in = ROW_W'(ROWS - 1);
                                    sw_col_in  = '0;
                                    sw_cend_in = COL_W'(COLS - 1);
                                    sw_rows_in = '0;
                                    state_in   = ST_SWEEP;
                                    if (rows_ff < RP_W'(SCROLLBACK)) begin
                                       sw_phys_in = phys_row(ring_ff, LOG_W'(rows_ff));
                                       rows_in    = rows_ff + 1'b1;
                                    end else begin
                                       sw_phys_in = ring_ff;
                                       ring_in    = (ring_ff == SB_W'(SCROLLBACK - 1))
                                                    ? '0 : ring_ff + 1'b1;
                                    end
                                 end else begin
                                    cur_row_in = cur_row_ff + 1'b1;
                                    if (glyph_pend_in) state_in = ST_WRITE;
                                 end
                              end
                           end
                        end
                        PH_ESC: begin
                           if (q_byte == CH_LBRACK) begin
                              phase_in   = PH_CSI;
                              seq_len_in = '0;
                           end else if (q_byte != CH_ESC) begin
                              phase_in = PH_GROUND;
                           end
                        end
                        default: begin
                           if (q_byte >= CH_AT && q_byte <= CH_TILDE) begin
                              phase_in = PH_GROUND;
                              fin_in   = q_byte;
                              pidx_in  = '0;
                              pn_in    = '0;
                              p0_in    = (q_byte == F_EL || q_byte == F_ED ||
                                          q_byte == F_SGR) ? '0 : PARAM_W'(1);
                              p1_in    = p0_in;
                              state_in = (seq_len_ff == '0) ? ST_PFIN : ST_PARSE;
                           end else if (q_byte == CH_ESC) begin
                              phase_in   = PH_ESC;
                              seq_len_in = '0;
                           end else if (seq_len_ff < SEQ_LW'(SEQ_MAX)) begin
                              seq_we     = 1'b1;
                              seq_len_in = seq_len_ff + 1'b1;
                           end
                        end
                     endcase
                  end
                  CMD_READ: begin
                     state_in = ST_RD_CALC;
                  end
                  CMD_SCROLL: begin
                     pan_sum = $signed({1'b0, (SUM_W - 1)'(pan_ff)}) +
                               SUM_W'($signed(q_delta));
                     if (pan_sum < 0) pan_in = '0;
                     else if (pan_sum > $signed({1'b0, (SUM_W - 1)'(screen_top)}))
                        pan_in = SB_W'(screen_top);
                     else pan_in = pan_sum[SB_W-1:0];
                  end
                  default: ;
               endcase
            end
         end

         ST_WRITE: begin
            ram_we        = 1'b1;
            ram_addr      = {phys_row(ring_ff, cur_logical), cur_col_ff[COL_W-1:0]};
            ram_wdata     = {pen_ff, glyph_ff};
            cur_col_in    = cur_col_ff + 1'b1;
            glyph_pend_in = 1'b0;
            state_in      = ST_DONE;
         end

         ST_RD_CALC: begin
            rd_top    = ((RP_W + 1)'(screen_top) > (RP_W + 1)'(pan_ff))
                        ? (RP_W + 1)'(screen_top) - (RP_W + 1)'(pan_ff) : '0;
            rd_log_in = LOG_W'(rd_top) + LOG_W'(vrow_ff);
            rd_hit_in = (32'(vrow_ff) < ROWS) && (32'(vcol_ff) < COLS) &&
                        (rd_log_in < LOG_W'(rows_ff));
            state_in  = ST_RD_ADDR;
         end

         ST_RD_ADDR: begin
            ram_addr = {phys_row(ring_ff, rd_log_ff), COL_W'(vcol_ff)};
            state_in = ST_RD_DATA;
         end

         ST_RD_DATA: begin
            cell_ch_in = rd_hit_ff ? ram_rdata[CHAR_W-1:0] : CH_SPACE;
            cell_at_in = rd_hit_ff ? ram_rdata[CELL_W-1:CHAR_W] : DFLT_ATTR;
            state_in   = ST_DONE;
         end

         ST_PARSE, ST_PFIN: begin
            pu_ctl.step   = (state_ff == ST_PARSE);
            pu_ctl.finish = (state_ff == ST_PFIN);
            if (pu_res.emit && pn_ff < pmax) begin
               if (pn_ff == PN_W'(0)) p0_in = pu_res.value;
               if (pn_ff == PN_W'(1)) p1_in = pu_res.value;
               if (fin_ff == F_SGR) pen_in = apply_sgr(pen_ff, pu_res.value);
               pn_in = pn_ff + 1'b1;
            end
            if (state_ff == ST_PFIN) begin
               state_in = ST_EXEC;
            end else if (SEQ_LW'(pidx_ff) == seq_len_ff - 1'b1) begin
               state_in = ST_PFIN;
            end else begin
               pidx_in = pidx_ff + 1'b1;
            end
         end

         ST_EXEC: begin
            seq_len_in = '0;
            state_in   = ST_DONE;
            sw_phys_in = phys_row(ring_ff, cur_logical);
            sw_rows_in = '0;
            sw_col_in  = '0;
            sw_cend_in = COL_W'(COLS - 1);
            case (fin_ff)
               F_CUP, F_HVP: begin
                  cur_row_in = abs_row(p0_ff);
                  cur_col_in = abs_col(p1_ff);
               end
               F_CUU: begin
                  cur_row_in = (step > PARAM_W'(cur_row_ff)) ? '0
                               : cur_row_ff - ROW_W'(step);
               end
               F_CUD: begin
                  sum_wide   = (PARAM_W + 1)'(cur_row_ff) + (PARAM_W + 1)'(step);
                  cur_row_in = (sum_wide > (PARAM_W + 1)'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                               : sum_wide[ROW_W-1:0];
               end
               F_CUF: begin
                  sum_wide   = (PARAM_W + 1)'(cur_col_ff) + (PARAM_W + 1)'(step);
                  cur_col_in = (sum_wide > (PARAM_W + 1)'(COLS)) ? CUR_COL_W'(COLS)
                               : sum_wide[CUR_COL_W-1:0];
               end
               F_CUB: begin
                  cur_col_in = (step > PARAM_W'(cur_col_ff)) ? '0
                               : cur_col_ff - CUR_COL_W'(step);
               end
               F_CHA: cur_col_in = abs_col(p0_ff);
               F_VPA: cur_row_in = abs_row(p0_ff);
               F_EL: begin
                  state_in = ST_SWEEP;
                  if (p0_ff == PARAM_W'(1)) begin
                     sw_cend_in = edge_col;
                  end else if (p0_ff != PARAM_W'(2)) begin
                     sw_col_in = edge_col;
                  end
               end
               F_ED: begin
                  state_in = ST_SWEEP;
                  if (p0_ff >= PARAM_W'(1) && p0_ff <= PARAM_W'(3)) begin
                     sw_phys_in = phys_row(ring_ff, LOG_W'(screen_top));
                     sw_rows_in = ROW_W'(ROWS - 1);
                  end else begin
                     sw_col_in  = edge_col;
                     sw_rows_in = ROW_W'(ROWS - 1) - cur_row_ff;
                  end
               end
               default: ;
            endcase
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, PAN_W'(screen_top), PAN_W'(pan_ff),
                               (cur_col_ff < CUR_COL_W'(COLS))
                                  ? OCOL_W'(cur_col_ff) : OCOL_W'(COLS - 1),
                               OROW_W'(cur_row_ff), cell_at_ff, cell_ch_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_ff[seq_len_ff[SEQ_IW-1:0]] <= q_byte;
      end
      glyph_ff    <= glyph_in;
      fin_ff      <= fin_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      vrow_ff     <= vrow_in;
      vcol_ff     <= vcol_in;
      rd_log_ff   <= rd_log_in;
      rd_hit_ff   <= rd_hit_in;
      cell_ch_ff  <= cell_ch_in;
      cell_at_ff  <= cell_at_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_SWEEP;
         phase_ff      <= PH_GROUND;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         pen_ff        <= DFLT_ATTR;
         ring_ff       <= '0;
         rows_ff       <= RP_W'(ROWS);
         pan_ff        <= '0;
         seq_len_ff    <= '0;
         glyph_pend_ff <= 1'b0;
         boot_ff       <= 1'b1;
         pidx_ff       <= '0;
         pn_ff         <= '0;
         sw_phys_ff    <= '0;
         sw_col_ff     <= '0;
         sw_cend_ff    <= COL_W'(COLS - 1);
         sw_rows_ff    <= ROW_W'(ROWS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         pen_ff        <= pen_in;
         ring_ff       <= ring_in;
         rows_ff       <= rows_in;
         pan_ff        <= pan_in;
         seq_len_ff    <= seq_len_in;
         glyph_pend_ff <= glyph_pend_in;
         boot_ff       <= boot_in;
         pidx_ff       <= pidx_in;
         pn_ff         <= pn_in;
         sw_phys_ff    <= sw_phys_in;
         sw_col_ff     <= sw_col_in;
         sw_cend_ff    <= sw_cend_in;
         sw_rows_ff    <= sw_rows_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// ===== sim/ansi_terminal_grid_engine_tb.sv =====
// Testbench for the terminal grid engine: random and directed command stream with a scoreboard.
module ansi_terminal_grid_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import atge_pkg::*;

   // Status-only command: no named code in the package, so name it here.
   localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2200;   // longer than a full-screen erase

   typedef enum int {PH_GROUND, PH_ESC, PH_CSI} parse_phase_e;

   // Expected contents of one response transaction.
   typedef struct {
      logic [CHAR_W-1:0] chr;
      logic [ATTR_W-1:0] attr;
      logic [OROW_W-1:0] crow;
      logic [OCOL_W-1:0] ccol;
      logic [PAN_W-1:0]  pan;
      logic [PAN_W-1:0]  pan_max;
   } status_t;

   // Terminal shadow: tracks grid, cursor, pen, parser and pan, and predicts
   // each response, then compares responses in order.
   class term_scoreboard;
      logic [CHAR_W-1:0] grid_chr [SCROLLBACK][COLS];
      logic [ATTR_W-1:0] grid_attr[SCROLLBACK][COLS];
      int base, present, crow, ccol, pan, seq_len;
      logic [ATTR_W-1:0] pen;
      logic [CHAR_W-1:0] seq[SEQ_MAX];
      parse_phase_e phase;
      status_t expected_q[$];
      int errors, matched, reads, feeds, pans, deepest;

      function new();
         for (int r = 0; r < SCROLLBACK; r++) clear_row(r);
         base = 0; present = ROWS; crow = 0; ccol = 0; pan = 0; seq_len = 0;
         pen = DFLT_ATTR; phase = PH_GROUND;
         errors = 0; matched = 0; reads = 0; feeds = 0; pans = 0; deepest = 0;
      endfunction

      function void clear_row(int p);
         for (int c = 0; c < COLS; c++) begin
            grid_chr[p][c] = CH_SPACE;
            grid_attr[p][c] = DFLT_ATTR;
         end
      endfunction

      function int phys(int logical);
         return (base + logical) % SCROLLBACK;
      endfunction

      function int top_row();
         return (present > ROWS) ? present - ROWS : 0;
      endfunction

      function void next_line();
         ccol = 0;
         if (crow >= ROWS - 1) begin
            // bottom row: push a blank row into the ring
            if (present < SCROLLBACK) begin
               clear_row(phys(present));
               present++;
            end else begin
               clear_row(base);
               base = (base + 1) % SCROLLBACK;
            end
            crow = ROWS - 1;
         end else begin
            crow++;
         end
         if (present - ROWS > deepest) deepest = present - ROWS;
      endfunction

      function void print_glyph(logic [CHAR_W-1:0] ch);
         int p;
         if (ccol >= COLS) next_line();
         p = phys(top_row() + crow);
         grid_chr[p][ccol] = ch;
         grid_attr[p][ccol] = pen;
         ccol++;
      endfunction

      function void clear_span(int lo, int hi);
         int p;
         p = phys(top_row() + crow);
         for (int c = lo; c <= hi && c < COLS; c++) begin
            grid_chr[p][c] = CH_SPACE;
            grid_attr[p][c] = DFLT_ATTR;
         end
      endfunction

      function int parse_args(ref int args[SGR_MAX + 2], input int limit, input int dflt);
         int n, val;
         bit have;
         n = 0; val = 0; have = 0;
         for (int i = 0; i < limit; i++) args[i] = dflt;
         for (int i = 0; i < seq_len && n < limit; i++) begin
            if (seq[i] >= CH_ZERO && seq[i] <= CH_NINE) begin
               val = val * 10 + int'(seq[i] - CH_ZERO);
               if (val > 65535) val = 65535;
               have = 1;
            end else if (seq[i] == CH_SEMI) begin
               args[n++] = have ? val : dflt;
               val = 0;
               have = 0;
            end
         end
         if (n < limit) args[n++] = have ? val : dflt;
         return n;
      endfunction

      function void place(int r, int c);
         crow = (r < 0) ? 0 : (r > ROWS - 1) ? ROWS - 1 : r;
         ccol = (c < 0) ? 0 : (c > COLS) ? COLS : c;
      endfunction

      function void apply_pen(int code);
         if (code == SGR_RESET) pen = DFLT_ATTR;
         else if (code == SGR_BOLD) pen[8] = 1'b1;
         else if (code == SGR_INV) pen[9] = 1'b1;
         else if (code == SGR_NOBOLD) pen[8] = 1'b0;
         else if (code == SGR_NOINV) pen[9] = 1'b0;
         else if (code >= SGR_FG_LO && code <= SGR_FG_HI) pen[3:0] = 4'(code - SGR_FG_LO);
         else if (code == SGR_FG_DFLT) pen[3:0] = 4'd8;
         else if (code >= SGR_BG_LO && code <= SGR_BG_HI) pen[7:4] = 4'(code - SGR_BG_LO);
         else if (code == SGR_BG_DFLT) pen[7:4] = 4'd8;
      endfunction

      function void run_final(logic [CHAR_W-1:0] fin);
         int args[SGR_MAX + 2];
         int n, edge_col, step;
         edge_col = (ccol < COLS) ? ccol : COLS - 1;
         case (fin)
            F_CUP, F_HVP: begin
               void'(parse_args(args, 2, 1));
               place(args[0] - 1, args[1] - 1);
            end
            F_CUU, F_CUD, F_CUF, F_CUB: begin
               void'(parse_args(args, 1, 1));
               step = (args[0] > 0) ? args[0] : 1;
               if (fin == F_CUU) place(crow - step, ccol);
               else if (fin == F_CUD) place(crow + step, ccol);
               else if (fin == F_CUF) place(crow, ccol + step);
               else place(crow, ccol - step);
            end
            F_CHA: begin
               void'(parse_args(args, 1, 1));
               place(crow, args[0] - 1);
            end
            F_VPA: begin
               void'(parse_args(args, 1, 1));
               place(args[0] - 1, ccol);
            end
            F_EL: begin
               void'(parse_args(args, 1, 0));
               if (args[0] == 1) clear_span(0, edge_col);
               else if (args[0] == 2) clear_span(0, COLS - 1);
               else clear_span(edge_col, COLS - 1);
            end
            F_ED: begin
               void'(parse_args(args, 1, 0));
               if (args[0] >= 1 && args[0] <= 3) begin
                  for (int r = 0; r < ROWS; r++) clear_row(phys(top_row() + r));
               end else begin
                  clear_span(edge_col, COLS - 1);
                  for (int r = crow + 1; r < ROWS; r++) clear_row(phys(top_row() + r));
               end
            end
            F_SGR: begin
               n = parse_args(args, SGR_MAX, 0);
               for (int i = 0; i < n; i++) apply_pen(args[i]);
            end
            default: ;
         endcase
      endfunction

      function void take_byte(logic [CHAR_W-1:0] b);
         int nxt;
         case (phase)
            PH_GROUND: begin
               if (b == CH_ESC) phase = PH_ESC;
               else if (b == CH_CR) ccol = 0;
               else if (b == CH_LF || b == CH_VT || b == CH_FF) next_line();
               else if (b == CH_BS) begin
                  if (ccol > 0) ccol--;
               end else if (b == CH_TAB) begin
                  nxt = (ccol / 8 + 1) * 8;
                  ccol = (nxt >= COLS) ? COLS - 1 : nxt;
               end else if (b >= CH_SPACE && b <= CH_TILDE) print_glyph(b);
               else if (b >= CH_HIGH && (b & UTF_MASK) != CH_HIGH) print_glyph(CH_QMARK);
            end
            PH_ESC: begin
               if (b == CH_LBRACK) begin
                  phase = PH_CSI;
                  seq_len = 0;
               end else if (b != CH_ESC) phase = PH_GROUND;
            end
            default: begin
               if (b >= CH_AT && b <= CH_TILDE) begin
                  run_final(b);
                  phase = PH_GROUND;
                  seq_len = 0;
               end else if (b == CH_ESC) begin
                  phase = PH_ESC;
                  seq_len = 0;
               end else if (seq_len < SEQ_MAX) seq[seq_len++] = b;
            end
         endcase
      endfunction

      // Note one accepted request and queue the response it must produce.
      function void note_request(logic [REQ_W-1:0] req);
         logic [CMD_W-1:0] cmd;
         int vr, vc, delta, first, logical, lim;
         status_t s;
         cmd = req[1:0];
         vr = req[14:10];
         vc = req[20:15];
         delta = $signed(req[30:21]);
         s.chr = '0;
         s.attr = '0;
         lim = (present > ROWS) ? present - ROWS : 0;
         if (cmd == CMD_FEED) begin
            take_byte(req[9:2]);
            pan = 0;
            feeds++;
         end else if (cmd == CMD_READ) begin
            reads++;
            s.chr = CH_SPACE;
            s.attr = DFLT_ATTR;
            if (vr < ROWS && vc < COLS) begin
               first = top_row() - pan;
               if (first < 0) first = 0;
               logical = first + vr;
               if (logical < present) begin
                  s.chr = grid_chr[phys(logical)][vc];
                  s.attr = grid_attr[phys(logical)][vc];
               end
            end
         end else if (cmd == CMD_SCROLL) begin
            pans++;
            pan = pan + delta;
            if (pan < 0) pan = 0;
            if (pan > lim) pan = lim;
         end
         lim = (present > ROWS) ? present - ROWS : 0;
         s.crow = crow;
         s.ccol = (ccol < COLS) ? ccol : COLS - 1;
         s.pan = pan;
         s.pan_max = lim;
         expected_q.push_back(s);
      endfunction

      function void report(string what, int exp_v, int act_v);
         errors++;
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(logic [RSP_W-1:0] d);
         status_t s;
         int bad;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response 0x%0h with nothing expected", $time, d);
            return;
         end
         s = expected_q.pop_front();
         bad = errors;
         if (d[7:0] !== s.chr) report("cell_char", s.chr, d[7:0]);
         if (d[17:8] !== s.attr) report("cell_attr", s.attr, d[17:8]);
         if (d[22:18] !== s.crow) report("cursor_row", s.crow, d[22:18]);
         if (d[28:23] !== s.ccol) report("cursor_col", s.ccol, d[28:23]);
         if (d[36:29] !== s.pan) report("view_offset", s.pan, d[36:29]);
         if (d[44:37] !== s.pan_max) report("view_max", s.pan_max, d[44:37]);
         if (errors == bad) matched++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   term_scoreboard sb;
   int sent = 0;
   int snd_idle_pct = 15;
   int rcv_idle_pct = 80;
   bit hold_now = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ansi_terminal_grid_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Offer one request transaction; return at the edge where it is accepted.
   // Random gaps drop valid first, so idles land on every phase of the work.
   task automatic send(logic [CMD_W-1:0] cmd, logic [7:0] b = 8'h00,
                       logic [4:0] vr = 5'd0, logic [5:0] vc = 6'd0,
                       logic [9:0] delta = 10'd0);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, delta, vc, vr, b, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_request({1'b0, delta, vc, vr, b, cmd});
      sent++;
      // Ask for one long receiver hold-off while requests keep coming.
      if (sent == 300) hold_now = 1;
   endtask

   task automatic feed(logic [7:0] b);
      send(CMD_FEED, b);
   endtask

   task automatic feed_str(string s);
      for (int i = 0; i < s.len(); i++) feed(s[i]);
   endtask

   task automatic read_cell(logic [4:0] r, logic [5:0] c);
      send(CMD_READ, 8'h00, r, c);
   endtask

   task automatic pan_view(logic [9:0] d);
      send(CMD_SCROLL, 8'h00, 5'd0, 6'd0, d);
   endtask

   // Drop valid and hold until every expected response has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // Random CSI sequence: a few parameters, sometimes junk, random final.
   task automatic random_csi();
      logic [7:0] finals[12] = '{F_CUP, F_HVP, F_CUU, F_CUD, F_CUF, F_CUB,
                                 F_CHA, F_VPA, F_EL, F_ED, F_SGR, 8'h7a};
      int sgr_codes[20] = '{0, 1, 7, 22, 27, 30, 31, 33, 35, 37, 39,
                            40, 42, 44, 46, 47, 49, 5, 38, 100};
      logic [7:0] fin;
      int nargs, v;
      string txt;
      fin = finals[$urandom_range(11)];
      // full-screen erases are slow, keep them rare
      if (fin == F_ED && $urandom_range(3) != 0) fin = F_EL;
      nargs = $urandom_range(0, (fin == F_SGR) ? 4 : 2);
      txt = "";
      for (int i = 0; i < nargs; i++) begin
         if (i > 0) txt = {txt, ";"};
         case ($urandom_range(9))
            0: ;                                  // empty parameter
            1: txt = {txt, "70000"};              // saturates
            2: txt = {txt, "?"};                  // skipped byte
            default: begin
               if (fin == F_SGR) v = sgr_codes[$urandom_range(19)];
               else v = $urandom_range(0, 70);
               txt = {txt, $sformatf("%0d", v)};
            end
         endcase
      end
      feed(CH_ESC);
      feed(CH_LBRACK);
      feed_str(txt);
      feed(fin);
   endtask

   // Receiver: check accepted responses, stall at random, one long hold.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_now) begin
            hold_now = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      #20ms;
      $display("ansi_terminal_grid_engine_tb: FAIL");
      $finish;
   end

   initial begin
      int kind, len;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: printable extremes, high bytes, controls, parser corners.
      feed(8'h20); feed(8'h7e); feed(8'hff); feed(8'h85); feed(8'h7f); feed(8'h01);
      feed(CH_TAB); feed(CH_BS); feed(CH_CR); feed(CH_LF); feed(CH_VT); feed(CH_FF);
      feed_str("\033x\033\033[99999;5H");   // dropped pair, ESC ESC, saturating CUP
      feed_str("\033[0A\033[200C");          // zero count, clamp to wrap column
      feed(8'h41); feed(CH_BS);              // print into wrap, back out of it
      feed_str("\033[1;7;31;44mZ\033[2K\033[1J\033[z");
      feed_str("\033[12\033[0123456789012345678;2H"); // abort, overflow
      read_cell(5'd31, 6'd63); read_cell(5'd0, 6'd0);
      pan_view(10'h100); pan_view(10'h300); send(CMD_STATUS);
      drain();

      // Random part across three idle regimes.
      while (sent < 2100) begin
         if (sent >= 1400) begin
            snd_idle_pct = 0; rcv_idle_pct = 0;
         end else if (sent >= 700 && snd_idle_pct == 15) begin
            drain();
            snd_idle_pct = 80; rcv_idle_pct = 15;
         end
         kind = $urandom_range(99);
         if (kind < 25) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               feed(($urandom_range(9) == 0) ? 8'($urandom_range(128, 255))
                                             : 8'($urandom_range(32, 126)));
         end else if (kind < 43) random_csi();
         else if (kind < 53) begin
            repeat ($urandom_range(1, 12)) feed(CH_LF);
         end else if (kind < 60) begin
            case ($urandom_range(3))
               0: feed(CH_CR);
               1: feed(CH_BS);
               2: feed(CH_TAB);
               default: feed(CH_VT);
            endcase
         end else if (kind < 82) begin
            repeat ($urandom_range(1, 6))
               read_cell(5'($urandom_range(31)), 6'($urandom_range(63)));
         end else if (kind < 90) begin
            pan_view(($urandom_range(3) == 0) ? 10'($urandom)
                                              : 10'($signed($urandom_range(0, 512)) - 256));
            repeat ($urandom_range(1, 4))
               read_cell(5'($urandom_range(31)), 6'($urandom_range(63)));
         end else if (kind < 95) begin
            if ($urandom_range(1)) send(CMD_STATUS, 8'($urandom), 5'($urandom),
                                        6'($urandom), 10'($urandom));
            else feed(8'($urandom));
         end else begin
            // broken sequences: bare ESC pairs, aborted or overlong CSI
            feed(CH_ESC);
            if ($urandom_range(1)) feed(8'($urandom));
            else begin
               feed(CH_LBRACK);
               repeat ($urandom_range(1, 20)) feed(8'($urandom_range(32, 63)));
               if ($urandom_range(1)) feed(CH_ESC);
            end
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d feeds, %0d cell reads, %0d pans; history grew to %0d rows.",
               sb.feeds, sb.reads, sb.pans, sb.deepest);
      $display("%0d responses matched, %0d field mismatches.", sb.matched, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("ansi_terminal_grid_engine_tb: PASS");
      end else begin
         $display("ansi_terminal_grid_engine_tb: FAIL");
      end
      $finish;
   end

endmodule
